// ----- rtl/fth_pkg.sv -----
// Shared types, codes and constant tables for the frequency text parser.
`timescale 1ns / 1ps
`default_nettype none

package fth_pkg;

   // Only the first nine fraction digits can reach a result in hertz (largest unit is 1e9).
   localparam int unsigned KeptFracDigits = 9;
   localparam int unsigned Frac3W         = 10;
   localparam int unsigned Frac6W         = 20;
   localparam int unsigned Frac9W         = 30;
   localparam int unsigned CntW           = 4;
   localparam int unsigned FreqW          = 64;
   localparam int unsigned WeightW        = 30;
   localparam int unsigned UnitCount      = 4;

   localparam logic [7:0] CharDot   = 8'h2E;
   localparam logic [7:0] CharSpace = 8'h20;
   localparam logic [7:0] CharTab   = 8'h09;
   localparam logic [7:0] CharZero  = 8'h30;
   localparam logic [7:0] CharNine  = 8'h39;
   localparam logic [7:0] CharUpA   = 8'h41;
   localparam logic [7:0] CharUpZ   = 8'h5A;
   localparam logic [7:0] CharLoA   = 8'h61;
   localparam logic [7:0] CharLoZ   = 8'h7A;
   localparam logic [7:0] CharH     = 8'h68;
   localparam logic [7:0] CharK     = 8'h6B;
   localparam logic [7:0] CharM     = 8'h6D;
   localparam logic [7:0] CharG     = 8'h67;
   localparam logic [7:0] CharZ     = 8'h7A;
   localparam logic [7:0] CaseShift = 8'h20;

   typedef enum logic [2:0] {
      PH_START,
      PH_INT,
      PH_FRAC,
      PH_BLANK,
      PH_UNIT,
      PH_DONE,
      PH_ERROR
   } phase_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NO_DIGIT = 2'd1,
      STATUS_BAD_UNIT = 2'd2,
      STATUS_OVERFLOW = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      UNIT_HZ  = 2'd0,
      UNIT_KHZ = 2'd1,
      UNIT_MHZ = 2'd2,
      UNIT_GHZ = 2'd3
   } unit_type;

   typedef struct packed {
      logic       step;
      logic       clear;
      logic [3:0] digit;
   } lane_ctrl_type;

   function automatic logic [WeightW-1:0] pow10(input logic [3:0] n);
      logic [WeightW-1:0] p;
      unique case (n)
         4'd0:    p = 30'd1;
         4'd1:    p = 30'd10;
         4'd2:    p = 30'd100;
         4'd3:    p = 30'd1000;
         4'd4:    p = 30'd10000;
         4'd5:    p = 30'd100000;
         4'd6:    p = 30'd1000000;
         4'd7:    p = 30'd10000000;
         4'd8:    p = 30'd100000000;
         4'd9:    p = 30'd1000000000;
         default: p = '0;
      endcase
      return p;
   endfunction

   // Expected letter of a unit at a given position, lower case.
   function automatic logic [7:0] unit_letter(input unit_type s, input logic [1:0] pos);
      logic [7:0] c;
      c = 8'h00;
      if (pos == 2'd0) begin
         unique case (s)
            UNIT_HZ:  c = CharH;
            UNIT_KHZ: c = CharK;
            UNIT_MHZ: c = CharM;
            UNIT_GHZ: c = CharG;
         endcase
      end else if (s == UNIT_HZ) begin
         if (pos == 2'd1) begin
            c = CharZ;
         end
      end else if (pos == 2'd1) begin
         c = CharH;
      end else if (pos == 2'd2) begin
         c = CharZ;
      end
      return c;
   endfunction

   function automatic logic [1:0] unit_length(input unit_type s);
      return (s == UNIT_HZ) ? 2'd2 : 2'd3;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/fth_lane.sv -----
// One integer accumulator lane: running integer part scaled by a fixed power of ten.
`timescale 1ns / 1ps
`default_nettype none

module fth_lane
   import fth_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire lane_ctrl_type         ctrl,
   input  wire logic [WeightW-1:0]    weight,
   output logic      [FreqW-1:0]      acc_nx,
   output logic                       ovf_nx
);

   logic [FreqW-1:0]   acc_ff;
   logic               ovf_ff;
   logic [FreqW+3:0]   acc_wide;
   logic [FreqW+3:0]   times_ten;
   logic [FreqW+3:0]   sum;
   logic [WeightW+3:0] dig_w;

   assign acc_wide  = {4'b0, acc_ff};
   assign times_ten = (acc_wide << 3) + (acc_wide << 1);
   assign dig_w     = {4'b0, weight} * {30'b0, ctrl.digit};
   assign sum       = times_ten + {34'b0, dig_w};

   // Overflow is sticky; the value is don't-care once it is set.
   always_comb begin
      acc_nx = acc_ff;
      ovf_nx = ovf_ff;
      if (ctrl.step) begin
         acc_nx = sum[FreqW-1:0];
         ovf_nx = ovf_ff | (|sum[FreqW+3:FreqW]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         acc_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         acc_ff <= acc_nx;
         ovf_ff <= ovf_nx;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/frequency_text_to_hertz.sv -----
// Top level: character parser, scaled accumulators, result add and output register.
// A finished string is held in the snapshot register, then in the result register on rsp_valid.
// Throughput: one character per cycle while req_ready is high; each of the four scaled
// accumulator lanes multiplies by ten combinationally; the final add sits in its own stage.
// Reset: synchronous, active high; clears the parse state and both valid flags.
`timescale 1ns / 1ps
`default_nettype none

module frequency_text_to_hertz
   import fth_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [7:0]       req_ch,
   input  wire logic             req_last,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic      [FreqW-1:0] rsp_freq_hz,
   output logic      [1:0]       rsp_status
);

   // parse state
   phase_type          phase_ff, phase_in, phase_nx;
   status_type         err_ff, err_in, err_nx;
   unit_type           scale_ff, scale_in, scale_nx;
   logic [1:0]         upos_ff, upos_in, upos_nx;
   logic [CntW-1:0]    cnt_ff, cnt_in, cnt_nx;
   logic [Frac3W-1:0]  frac3_ff, frac3_in, frac3_nx;
   logic [Frac6W-1:0]  frac6_ff, frac6_in, frac6_nx;
   logic [Frac9W-1:0]  frac9_ff, frac9_in, frac9_nx;

   // snapshot of a finished string
   logic               snap_valid_ff, snap_valid_in;
   status_type         snap_err_ff, snap_err_in;
   logic [FreqW-1:0]   snap_int_ff, snap_int_in;
   logic               snap_ovf_ff, snap_ovf_in;
   logic [Frac9W-1:0]  snap_frac_ff, snap_frac_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [FreqW-1:0]   rsp_freq_ff, rsp_freq_in;
   status_type         rsp_status_ff, rsp_status_in;

   logic               accept, out_free, snap_go;
   logic               ch_num, is_blank, is_letter;
   logic [7:0]         lc;
   logic [3:0]         dval;
   status_type         fin_err;
   lane_ctrl_type      lane_ctrl;
   logic [FreqW-1:0]   lane_acc [UnitCount];
   logic               lane_ovf [UnitCount];
   logic [FreqW:0]     total;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign snap_go   = snap_valid_ff && out_free;
   assign req_ready = !snap_valid_ff || out_free;
   assign accept    = req_valid && req_ready;

   assign ch_num    = (req_ch >= CharZero) && (req_ch <= CharNine);
   assign dval      = req_ch[3:0];
   assign lc        = ((req_ch >= CharUpA) && (req_ch <= CharUpZ)) ? req_ch + CaseShift : req_ch;
   assign is_blank  = (lc == CharSpace) || (lc == CharTab);
   assign is_letter = (lc >= CharLoA) && (lc <= CharLoZ);

   assign lane_ctrl.step  = accept && ch_num && ((phase_ff == PH_START) || (phase_ff == PH_INT));
   assign lane_ctrl.clear = accept && req_last;
   assign lane_ctrl.digit = dval;

   for (genvar i = 0; i < UnitCount; i++) begin : g_lane
      fth_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .ctrl   (lane_ctrl),
         .weight (pow10(4'(3 * i))),
         .acc_nx (lane_acc[i]),
         .ovf_nx (lane_ovf[i])
      );
   end

   // Character step: effect of the current character on the parse state.
   always_comb begin
      phase_nx = phase_ff;
      err_nx   = err_ff;
      scale_nx = scale_ff;
      upos_nx  = upos_ff;
      cnt_nx   = cnt_ff;
      frac3_nx = frac3_ff;
      frac6_nx = frac6_ff;
      frac9_nx = frac9_ff;

      unique case (phase_ff)
         PH_START: begin
            if (ch_num) begin
               phase_nx = PH_INT;
            end else begin
               err_nx   = STATUS_NO_DIGIT;
               phase_nx = PH_ERROR;
            end
         end
         PH_INT, PH_FRAC, PH_BLANK: begin
            if (ch_num && (phase_ff != PH_BLANK)) begin
               if ((phase_ff == PH_FRAC) && (cnt_ff < CntW'(KeptFracDigits))) begin
                  cnt_nx   = cnt_ff + 1'b1;
                  frac9_nx = frac9_ff + pow10(4'd8 - cnt_ff) * Frac9W'(dval);
                  if (cnt_ff < 4'd6) begin
                     frac6_nx = frac6_ff + Frac6W'(pow10(4'd5 - cnt_ff) * Frac9W'(dval));
                  end
                  if (cnt_ff < 4'd3) begin
                     frac3_nx = frac3_ff + Frac3W'(pow10(4'd2 - cnt_ff) * Frac9W'(dval));
                  end
               end
            end else if ((phase_ff == PH_INT) && (req_ch == CharDot)) begin
               phase_nx = PH_FRAC;
            end else if (is_blank) begin
               phase_nx = PH_BLANK;
            end else if (is_letter) begin
               upos_nx  = 2'd1;
               phase_nx = PH_UNIT;
               priority case (lc)
                  CharH:   scale_nx = UNIT_HZ;
                  CharK:   scale_nx = UNIT_KHZ;
                  CharM:   scale_nx = UNIT_MHZ;
                  CharG:   scale_nx = UNIT_GHZ;
                  default: begin
                     upos_nx  = upos_ff;
                     err_nx   = STATUS_BAD_UNIT;
                     phase_nx = PH_ERROR;
                  end
               endcase
            end else begin
               // anything else closes the number in plain hertz
               scale_nx = UNIT_HZ;
               phase_nx = PH_DONE;
            end
         end
         PH_UNIT: begin
            if (lc == unit_letter(scale_ff, upos_ff)) begin
               upos_nx = upos_ff + 1'b1;
               if (upos_nx >= unit_length(scale_ff)) begin
                  phase_nx = PH_DONE;
               end
            end else begin
               err_nx   = STATUS_BAD_UNIT;
               phase_nx = PH_ERROR;
            end
         end
         default: begin
         end
      endcase
   end

   // a string that stops inside a unit counts as a bad unit
   assign fin_err = ((phase_nx == PH_UNIT) && (err_nx == STATUS_OK)) ? STATUS_BAD_UNIT : err_nx;

   always_comb begin
      phase_in = phase_ff;
      err_in   = err_ff;
      scale_in = scale_ff;
      upos_in  = upos_ff;
      cnt_in   = cnt_ff;
      frac3_in = frac3_ff;
      frac6_in = frac6_ff;
      frac9_in = frac9_ff;
      if (accept) begin
         if (req_last) begin
            phase_in = PH_START;
            err_in   = STATUS_OK;
            scale_in = UNIT_HZ;
            upos_in  = '0;
            cnt_in   = '0;
            frac3_in = '0;
            frac6_in = '0;
            frac9_in = '0;
         end else begin
            phase_in = phase_nx;
            err_in   = err_nx;
            scale_in = scale_nx;
            upos_in  = upos_nx;
            cnt_in   = cnt_nx;
            frac3_in = frac3_nx;
            frac6_in = frac6_nx;
            frac9_in = frac9_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         err_ff   <= STATUS_OK;
         scale_ff <= UNIT_HZ;
         upos_ff  <= '0;
         cnt_ff   <= '0;
         frac3_ff <= '0;
         frac6_ff <= '0;
         frac9_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         err_ff   <= err_in;
         scale_ff <= scale_in;
         upos_ff  <= upos_in;
         cnt_ff   <= cnt_in;
         frac3_ff <= frac3_in;
         frac6_ff <= frac6_in;
         frac9_ff <= frac9_in;
      end
   end

   // Snapshot: pick the lane and truncated fraction for the unit seen.
   always_comb begin
      snap_valid_in = snap_valid_ff;
      if (accept && req_last) begin
         snap_valid_in = 1'b1;
      end else if (snap_go) begin
         snap_valid_in = 1'b0;
      end
      snap_err_in = fin_err;
      unique case (scale_nx)
         UNIT_HZ: begin
            snap_int_in  = lane_acc[0];
            snap_ovf_in  = lane_ovf[0];
            snap_frac_in = '0;
         end
         UNIT_KHZ: begin
            snap_int_in  = lane_acc[1];
            snap_ovf_in  = lane_ovf[1];
            snap_frac_in = Frac9W'(frac3_nx);
         end
         UNIT_MHZ: begin
            snap_int_in  = lane_acc[2];
            snap_ovf_in  = lane_ovf[2];
            snap_frac_in = Frac9W'(frac6_nx);
         end
         UNIT_GHZ: begin
            snap_int_in  = lane_acc[3];
            snap_ovf_in  = lane_ovf[3];
            snap_frac_in = frac9_nx;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         snap_valid_ff <= 1'b0;
      end else begin
         snap_valid_ff <= snap_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_last) begin
         snap_err_ff  <= snap_err_in;
         snap_int_ff  <= snap_int_in;
         snap_ovf_ff  <= snap_ovf_in;
         snap_frac_ff <= snap_frac_in;
      end
   end

   // Result stage: integer plus fraction, with error and overflow handling.
   assign total = {1'b0, snap_int_ff} + (FreqW + 1)'(snap_frac_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (snap_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (snap_err_ff != STATUS_OK) begin
         rsp_freq_in   = '0;
         rsp_status_in = snap_err_ff;
      end else if (snap_ovf_ff || total[FreqW]) begin
         rsp_freq_in   = '1;
         rsp_status_in = STATUS_OVERFLOW;
      end else begin
         rsp_freq_in   = total[FreqW-1:0];
         rsp_status_in = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (snap_go) begin
         rsp_freq_ff   <= rsp_freq_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_freq_hz = rsp_freq_ff;
   assign rsp_status  = rsp_status_ff;

endmodule

`default_nettype wire

// ----- rtl/fth_checker.sv -----
// Port-level checks for the frequency text parser, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module fth_checker
   import fth_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic             req_last,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire logic [FreqW-1:0] rsp_freq_hz,
   input wire logic [1:0]       rsp_status
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid straight after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_freq_hz) && $stable(rsp_status))
      else $error("stalled result item changed or dropped");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_status == STATUS_NO_DIGIT) || (rsp_status == STATUS_BAD_UNIT))
      |-> (rsp_freq_hz == '0))
      else $error("error status with non-zero frequency");

   a_ovf_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_OVERFLOW) |-> (&rsp_freq_hz))
      else $error("overflow status without saturated frequency");

   a_last_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last && !rsp_valid |=> ##1 rsp_valid)
      else $error("last item accepted into an idle output gave no result");

endmodule

bind frequency_text_to_hertz fth_checker u_fth_checker (.*);

`default_nettype wire
